### hw/rtl/lhm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhm_pkg
// Shared types and constants of the latency histogram monitor.
// ----------------------------------------------------------------------------
package lhm_pkg;

  localparam int LAT_W        = 32;
  localparam int SUM_W        = 48;
  localparam int CNT_W        = 32;
  localparam int IDX_W        = 6;
  localparam int TYPE_W       = 2;
  localparam int NUM_BINS_DEF = 64;

  // request codes
  localparam logic [TYPE_W-1:0] REQ_RECORD = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_LOG    = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_READ   = 2'd2;

  typedef struct packed {
    logic [TYPE_W-1:0] req_type;
    logic [LAT_W-1:0]  latency;
    logic [IDX_W-1:0]  bin_index;
  } req_t;

  typedef struct packed {
    logic [CNT_W-1:0] bin_count;
    logic [LAT_W-1:0] min_lat;
    logic [LAT_W-1:0] max_lat;
    logic [SUM_W-1:0] sum_lat;
    logic [CNT_W-1:0] xact_count;
  } rsp_t;

  // update strobe from the pipeline to the statistics registers
  typedef struct packed {
    logic             record;
    logic             log;
    logic [LAT_W-1:0] latency;
  } stats_upd_t;

  // statistics as they stand after an update
  typedef struct packed {
    logic [LAT_W-1:0] min_lat;
    logic [LAT_W-1:0] max_lat;
    logic [SUM_W-1:0] sum_lat;
    logic [CNT_W-1:0] xact_count;
  } stats_t;

endpackage

### hw/rtl/lhm_hist_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhm_hist_ram
// Histogram bin storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lhm_hist_ram #(
  parameter int DEPTH = lhm_pkg::NUM_BINS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [AW-1:0]           waddr,
  input  logic [lhm_pkg::CNT_W-1:0] wdata,
  input  logic                    re,
  input  logic [AW-1:0]           raddr,
  output logic [lhm_pkg::CNT_W-1:0] rdata
);
  import lhm_pkg::*;

  logic [CNT_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, old data on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/lhm_stats.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhm_stats
// Running minimum, maximum, saturating sum and saturating transaction count.
// ----------------------------------------------------------------------------
module lhm_stats (
  input  logic                clk,
  input  logic                rst,
  input  lhm_pkg::stats_upd_t upd,
  output lhm_pkg::stats_t     stats_next
);
  import lhm_pkg::*;

  logic [LAT_W-1:0] min_seen;
  logic [LAT_W-1:0] max_seen;
  logic [SUM_W-1:0] sum_seen;
  logic [CNT_W-1:0] transactions;
  logic [SUM_W:0]   sum_wide;

  // values after this update
  always_comb begin
    sum_wide   = {1'b0, sum_seen} + {{(SUM_W + 1 - LAT_W){1'b0}}, upd.latency};
    stats_next.min_lat    = min_seen;
    stats_next.max_lat    = max_seen;
    stats_next.sum_lat    = sum_seen;
    stats_next.xact_count = transactions;
    if (upd.record) begin
      stats_next.sum_lat = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
      if (upd.latency < min_seen) begin
        stats_next.min_lat = upd.latency;
      end
      if (upd.latency > max_seen) begin
        stats_next.max_lat = upd.latency;
      end
    end
    if (upd.log && (transactions != {CNT_W{1'b1}})) begin
      stats_next.xact_count = transactions + 1'b1;
    end
  end

  // statistics registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_seen     <= {LAT_W{1'b1}};
      max_seen     <= '0;
      sum_seen     <= '0;
      transactions <= '0;
    end else begin
      min_seen     <= stats_next.min_lat;
      max_seen     <= stats_next.max_lat;
      sum_seen     <= stats_next.sum_lat;
      transactions <= stats_next.xact_count;
    end
  end

endmodule

### hw/rtl/latency_histogram_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// latency_histogram_monitor
// Records latency samples into a histogram memory with running statistics.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  req     | in        | req_valid, req_stall | req  (req_type, latency, bin_index)
//  rsp     | out       | rsp_valid, rsp_stall | rsp  (bin_count, min/max, sum, count)
//
//  A request is read from the bin memory in the cycle it is taken and held in
//  the update stage, which applies it to the bin and statistics and loads the
//  result register; one request per cycle is sustained while results are not
//  stalled. A bin hit by two requests in a row is forwarded around the memory.
//  After reset a clearing pass zeroes the bins with req_stall high. A stalled
//  result holds the update stage, which then stalls requests.
// ----------------------------------------------------------------------------
module latency_histogram_monitor #(
  parameter int NUM_BINS = lhm_pkg::NUM_BINS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  lhm_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output lhm_pkg::rsp_t rsp
);
  import lhm_pkg::*;

  localparam int BIN_W = $clog2(NUM_BINS);
  localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(NUM_BINS - 1);

  // clearing pass
  logic             clearing;
  logic [BIN_W-1:0] clr_idx;

  // update stage
  logic              s1_valid;
  logic [TYPE_W-1:0] s1_type;
  logic [LAT_W-1:0]  s1_lat;
  logic [BIN_W-1:0]  s1_addr;
  logic              s1_rd_ok;
  logic              fwd_hit;
  logic [CNT_W-1:0]  fwd_data;

  logic              accept;
  logic              s1_adv;
  logic              wr_fire;
  logic [BIN_W-1:0]  rd_addr;
  logic              rd_ok;
  logic              rd_en;
  logic [CNT_W-1:0]  rdata;
  logic [CNT_W-1:0]  cnt_cur;
  logic [CNT_W-1:0]  cnt_new;
  logic [CNT_W-1:0]  bin_count;
  logic              mem_we;
  logic [BIN_W-1:0]  mem_waddr;
  logic [CNT_W-1:0]  mem_wdata;
  stats_upd_t        upd;
  stats_t            stats_next;

  // handshake
  assign s1_adv    = s1_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = clearing || (s1_valid && !s1_adv);
  assign accept    = req_valid && !req_stall;

  // bin selection for the incoming request
  always_comb begin
    rd_ok   = 1'b0;
    rd_addr = LAST_BIN;
    if (req.req_type == REQ_RECORD) begin
      rd_ok = 1'b1;
      if (req.latency < LAT_W'(NUM_BINS)) begin
        rd_addr = BIN_W'(req.latency);
      end
    end else if (req.req_type == REQ_READ) begin
      rd_ok   = {{(LAT_W - IDX_W){1'b0}}, req.bin_index} < LAT_W'(NUM_BINS);
      rd_addr = BIN_W'(req.bin_index);
    end
  end

  assign rd_en = accept && rd_ok;

  // bin update and result count
  assign cnt_cur = fwd_hit ? fwd_data : rdata;
  assign cnt_new = (cnt_cur == {CNT_W{1'b1}}) ? cnt_cur : cnt_cur + 1'b1;
  assign wr_fire = s1_adv && (s1_type == REQ_RECORD);

  always_comb begin
    bin_count = '0;
    if (s1_type == REQ_RECORD) begin
      bin_count = cnt_new;
    end else if ((s1_type == REQ_READ) && s1_rd_ok) begin
      bin_count = cnt_cur;
    end
  end

  // memory write: clearing pass or bin update
  assign mem_we    = clearing || wr_fire;
  assign mem_waddr = clearing ? clr_idx : s1_addr;
  assign mem_wdata = clearing ? '0 : cnt_new;

  lhm_hist_ram #(
    .DEPTH (NUM_BINS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  // statistics
  assign upd.record  = s1_adv && (s1_type == REQ_RECORD);
  assign upd.log     = s1_adv && (s1_type == REQ_LOG);
  assign upd.latency = s1_lat;

  lhm_stats u_stats (
    .clk        (clk),
    .rst        (rst),
    .upd        (upd),
    .stats_next (stats_next)
  );

  // clearing pass control
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + 1'b1;
      if (clr_idx == LAST_BIN) begin
        clearing <= 1'b0;
      end
    end
  end

  // update stage registers and forwarding
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
    if (accept) begin
      s1_type  <= req.req_type;
      s1_lat   <= req.latency;
      s1_addr  <= rd_addr;
      s1_rd_ok <= rd_ok;
      fwd_hit  <= wr_fire && (s1_addr == rd_addr);
      fwd_data <= cnt_new;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_adv) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
    if (s1_adv) begin
      rsp.bin_count  <= bin_count;
      rsp.min_lat    <= stats_next.min_lat;
      rsp.max_lat    <= stats_next.max_lat;
      rsp.sum_lat    <= stats_next.sum_lat;
      rsp.xact_count <= stats_next.xact_count;
    end
  end

endmodule

### tb/tb_latency_histogram_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_latency_histogram_monitor
// Self-checking bench for the latency histogram monitor. Requests from a
// directed table and then from a random mix of record, log, read and spare
// requests are driven on the request channel. An in-bench copy of the bins
// and running statistics predict untyped responses, and each response is
// compared field by field. Random idle bursts on both channels, a long
// response hold-off and a closing run of large latencies are included.
// ----------------------------------------------------------------------------
module tb_latency_histogram_monitor;
  import lhm_pkg::*;

  localparam logic [TYPE_W-1:0] REQ_SPARE = 2'd3;
  localparam int  CYCLE_LIMIT   = 1000000;
  localparam int  LONG_HOLD     = 200;
  localparam int  RANDOM_BLOCKS = 13;
  localparam int  BLOCK_ITEMS   = 100;
  localparam int  TAIL_ITEMS    = 40;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [LAT_W-1:0] LAT_MAX = '1;

  typedef struct packed {
    req_t item;
    logic typed;
    rsp_t want;
  } dir_row_t;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  // typed-in expectation traveling with the request
  logic fixed_use;
  rsp_t fixed_rsp;

  bit idle_on;
  bit hold_start;
  int mismatches;
  int tick_count;

  // shadow copy of the bins and statistics
  logic [CNT_W-1:0] hist_model [NUM_BINS_DEF];
  logic [LAT_W-1:0] min_model;
  logic [LAT_W-1:0] max_model;
  logic [SUM_W-1:0] sum_model;
  logic [CNT_W-1:0] txn_model;

  rsp_t     due_rsps [$];
  dir_row_t dir_rows [$];

  latency_histogram_monitor dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  initial tick_count = 0;
  always @(posedge clk) begin
    tick_count++;
    if (tick_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic rsp_t stats_view(input logic [CNT_W-1:0] cnt,
                                      input logic [LAT_W-1:0] lo,
                                      input logic [LAT_W-1:0] hi,
                                      input logic [SUM_W-1:0] sum,
                                      input logic [CNT_W-1:0] txn);
    return {cnt, lo, hi, sum, txn};
  endfunction

  // apply one request to the shadow state, return the response it yields
  function automatic rsp_t apply_request(input req_t r);
    rsp_t             o;
    logic [SUM_W:0]   wide;
    logic [IDX_W-1:0] bin;
    o = '0;
    case (r.req_type)
      REQ_RECORD: begin
        wide = {1'b0, sum_model} + {{(SUM_W + 1 - LAT_W){1'b0}}, r.latency};
        sum_model = wide[SUM_W] ? {SUM_W{1'b1}} : wide[SUM_W-1:0];
        if (r.latency > max_model) max_model = r.latency;
        if (r.latency < min_model) min_model = r.latency;
        // anything at or past the last bin lands in the last bin
        if (r.latency < NUM_BINS_DEF) bin = r.latency[IDX_W-1:0];
        else bin = IDX_W'(NUM_BINS_DEF - 1);
        if (hist_model[bin] != CNT_MAX) hist_model[bin] = hist_model[bin] + 1'b1;
        o.bin_count = hist_model[bin];
      end
      REQ_LOG: begin
        if (txn_model != CNT_MAX) txn_model = txn_model + 1'b1;
      end
      REQ_READ: begin
        o.bin_count = hist_model[r.bin_index];
      end
      default: begin
      end
    endcase
    o.min_lat    = min_model;
    o.max_lat    = max_model;
    o.sum_lat    = sum_model;
    o.xact_count = txn_model;
    return o;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %0h, got %0h", name, want, got);
    end
  endtask

  // predict on request accept, compare on response accept
  always @(posedge clk) begin : scoreboard
    rsp_t predicted;
    rsp_t want;
    if (!rst) begin
      if (req_valid && !req_stall) begin
        predicted = apply_request(req);
        due_rsps.push_back(fixed_use ? fixed_rsp : predicted);
      end
      if (rsp_valid && !rsp_stall) begin
        if (due_rsps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("response with none expected: bin_count %0h", rsp.bin_count);
        end else begin
          want = due_rsps.pop_front();
          check_field("bin_count",  64'(want.bin_count),  64'(rsp.bin_count));
          check_field("min_lat",    64'(want.min_lat),    64'(rsp.min_lat));
          check_field("max_lat",    64'(want.max_lat),    64'(rsp.max_lat));
          check_field("sum_lat",    64'(want.sum_lat),    64'(rsp.sum_lat));
          check_field("xact_count", 64'(want.xact_count), 64'(rsp.xact_count));
        end
      end
    end
  end

  // response stall: random bursts, plus one long hold-off on request
  initial begin
    rsp_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_start) begin
        hold_start = 1'b0;
        rsp_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        rsp_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        rsp_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(negedge clk);
        rsp_stall <= 1'b0;
      end
    end
  end

  // drive one request from a falling edge, return at the falling edge after accept
  task automatic send_req(input req_t r, input logic typed, input rsp_t want);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    fixed_use <= typed;
    fixed_rsp <= want;
    do @(posedge clk); while (req_stall);
    @(negedge clk);
  endtask

  // drop valid and wait for every outstanding response
  task automatic wait_drained();
    req_valid <= 1'b0;
    while (due_rsps.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic add_dir(input logic [TYPE_W-1:0] kind, input logic [LAT_W-1:0] lat,
                         input logic [IDX_W-1:0] idx, input logic typed,
                         input rsp_t want);
    dir_row_t row;
    row.item.req_type  = kind;
    row.item.latency   = lat;
    row.item.bin_index = idx;
    row.typed          = typed;
    row.want           = want;
    dir_rows.push_back(row);
  endtask

  // random request; reads often target the bin just recorded
  function automatic req_t random_request(input logic [IDX_W-1:0] recent_bin);
    req_t r;
    int   pick;
    int   lsel;
    pick = $urandom_range(0, 99);
    lsel = $urandom_range(0, 9);
    if (pick < 45) r.req_type = REQ_RECORD;
    else if (pick < 65) r.req_type = REQ_LOG;
    else if (pick < 95) r.req_type = REQ_READ;
    else r.req_type = REQ_SPARE;
    if (lsel < 6) r.latency = $urandom_range(0, 70);
    else if (lsel < 8) r.latency = $urandom;
    else if (lsel == 8) r.latency = LAT_MAX;
    else r.latency = $urandom_range(0, 3);
    r.bin_index = IDX_W'($urandom_range(0, 63));
    if (r.req_type == REQ_READ && $urandom_range(0, 2) == 0) r.bin_index = recent_bin;
    return r;
  endfunction

  initial begin : stimulus
    req_t             r;
    logic [IDX_W-1:0] recent_bin;
    rsp_t             none;
    none       = '0;
    recent_bin = '0;
    rst        = 1'b1;
    req_valid  = 1'b0;
    req        = '0;
    fixed_use  = 1'b0;
    fixed_rsp  = '0;
    idle_on    = 1'b1;
    hold_start = 1'b0;
    mismatches = 0;
    for (int i = 0; i < NUM_BINS_DEF; i++) hist_model[i] = '0;
    min_model = '1;
    max_model = '0;
    sum_model = '0;
    txn_model = '0;

    // directed table: reset view, extremes, every request code, last-bin folding
    add_dir(REQ_READ,   32'd0,   6'd0,  1'b1,
            stats_view(32'd0, LAT_MAX, 32'd0, 48'd0, 32'd0));
    add_dir(REQ_READ,   32'd0,   6'd63, 1'b1,
            stats_view(32'd0, LAT_MAX, 32'd0, 48'd0, 32'd0));
    add_dir(REQ_SPARE,  LAT_MAX, 6'd63, 1'b1,
            stats_view(32'd0, LAT_MAX, 32'd0, 48'd0, 32'd0));
    add_dir(REQ_LOG,    LAT_MAX, 6'd63, 1'b1,
            stats_view(32'd0, LAT_MAX, 32'd0, 48'd0, 32'd1));
    add_dir(REQ_RECORD, 32'd0,   6'd63, 1'b1,
            stats_view(32'd1, 32'd0, 32'd0, 48'd0, 32'd1));
    add_dir(REQ_RECORD, LAT_MAX, 6'd0,  1'b1,
            stats_view(32'd1, 32'd0, LAT_MAX, 48'h0000_FFFF_FFFF, 32'd1));
    add_dir(REQ_RECORD, 32'd64,  6'd0,  1'b0, none);
    add_dir(REQ_RECORD, 32'd63,  6'd0,  1'b0, none);
    add_dir(REQ_RECORD, 32'd63,  6'd0,  1'b0, none);
    add_dir(REQ_RECORD, 32'd62,  6'd0,  1'b0, none);
    add_dir(REQ_RECORD, 32'd1,   6'd0,  1'b0, none);
    add_dir(REQ_RECORD, 32'd1,   6'd0,  1'b0, none);
    add_dir(REQ_RECORD, 32'd0,   6'd0,  1'b0, none);
    add_dir(REQ_READ,   32'd0,   6'd63, 1'b0, none);
    add_dir(REQ_READ,   LAT_MAX, 6'd0,  1'b0, none);
    add_dir(REQ_READ,   32'd0,   6'd1,  1'b0, none);
    add_dir(REQ_READ,   32'd0,   6'd62, 1'b0, none);
    add_dir(REQ_READ,   32'd0,   6'd2,  1'b0, none);
    add_dir(REQ_RECORD, 32'd5,   6'd0,  1'b0, none);
    add_dir(REQ_READ,   32'd0,   6'd5,  1'b0, none);
    add_dir(REQ_LOG,    32'd0,   6'd0,  1'b0, none);
    add_dir(REQ_SPARE,  32'd0,   6'd0,  1'b0, none);
    add_dir(REQ_RECORD, 32'h8000_0000, 6'd21, 1'b0, none);
    add_dir(REQ_RECORD, 32'h7FFF_FFFF, 6'd42, 1'b0, none);

    // synchronous reset
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_req(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
    wait_drained();

    // random mix, idling switched off in some blocks
    for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      idle_on = (blk % 4 != 3);
      for (int n = 0; n < BLOCK_ITEMS; n++) begin
        r = random_request(recent_bin);
        if (r.req_type == REQ_RECORD)
          recent_bin = (r.latency < NUM_BINS_DEF) ? r.latency[IDX_W-1:0] : IDX_W'(63);
        send_req(r, 1'b0, none);
      end
    end
    wait_drained();

    // long response hold-off while requests keep coming
    idle_on    = 1'b0;
    hold_start = 1'b1;
    for (int n = 0; n < 60; n++) send_req(random_request(recent_bin), 1'b0, none);
    wait_drained();

    // large latencies back to back, then a random mix, no idling from here on
    r.req_type  = REQ_RECORD;
    r.bin_index = '0;
    for (int n = 0; n < TAIL_ITEMS; n++) begin
      r.latency = LAT_MAX - $urandom_range(0, 255);
      send_req(r, 1'b0, none);
    end
    for (int n = 0; n < 40; n++) send_req(random_request(6'd63), 1'b0, none);
    wait_drained();

    repeat (8) @(posedge clk);
    if (mismatches == 0 && due_rsps.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
